// ===== rtl/lxmc_pkg.sv =====
// Shared types and constants for the LRU local-to-distributed id map cache.
// No dependencies; the modules in rtl/ import this package.
package lxmc_pkg;

  localparam int unsigned XID_W = 32;
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } op_e;

  typedef struct packed {
    op_e              opcode;
    logic [XID_W-1:0] local_xid;
    logic [XID_W-1:0] distrib_xid;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [XID_W-1:0] found_distrib_xid;
    logic             duplicate_error;
  } rsp_t;

  typedef logic [CAP_W-1:0] cap_t;

endpackage

// ===== rtl/lxmc_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per request.
// Depends on nothing; payload types come from lxmc_pkg at instantiation.
interface lxmc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lxmc_value_ram.sv =====
// Value store of the map cache: one write and one registered read per cycle.
// Depends on lxmc_pkg for the id width.
module lxmc_value_ram
  import lxmc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [XID_W-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [XID_W-1:0]           rdata_o
);

  logic [XID_W-1:0] mem [ENTRIES];
  logic [XID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lxmc_entry_store.sv =====
// Key, valid and age-rank cells of the map cache with parallel compare,
// eviction, insert-slot search and LRU rank update. Depends on lxmc_pkg.
module lxmc_entry_store
  import lxmc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned CW      = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  op_e                        opcode_i,
  input  logic [XID_W-1:0]           key_i,
  input  logic [CW-1:0]              cap_i,
  output logic                       hit_o,
  output logic                       dup_o,
  output logic                       ins_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0] ins_idx_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [XID_W-1:0]   key_q  [ENTRIES];
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  logic               cap_ok;
  logic               is_add;
  logic [ENTRIES-1:0] eq;
  logic [ENTRIES-1:0] evict;
  logic [ENTRIES-1:0] keep;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] ins_onehot;
  logic [IW-1:0]      hit_rank;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      ins_idx;

  assign cap_ok = (cap_i != '0);
  assign is_add = (opcode_i == OP_ADD);

  // Ranks of valid entries form 0..count-1, so evicting down to cap-1
  // entries drops exactly those with rank >= cap-1.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      eq[i]    = valid_q[i] && (key_q[i] == key_i);
      evict[i] = is_add && cap_ok && valid_q[i] &&
                 ((CW'(rank_q[i]) + CW'(1)) >= cap_i);
      keep[i]  = valid_q[i] && !evict[i];
    end
  end

  assign free       = ~keep;
  assign ins_onehot = free & (~free + ENTRIES'(1));

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    ins_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (eq[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (ins_onehot[i]) begin
        ins_idx = ins_idx | IW'(i);
      end
    end
  end

  assign hit_o     = !is_add && cap_ok && (|eq);
  assign dup_o     = is_add && cap_ok && (|(eq & keep));
  assign ins_o     = is_add && cap_ok && !(|(eq & keep));
  assign hit_idx_o = hit_idx;
  assign ins_idx_o = ins_idx;

  // Drop evicted entries and mark the insert slot live in one update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= keep | (ins_o ? ins_onehot : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins_o) begin
          if (ins_onehot[i]) begin
            rank_q[i] <= '0;
          end else if (keep[i]) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end else if (hit_o) begin
          if (eq[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (en_i && ins_o && ins_onehot[i]) begin
        key_q[i] <= key_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_ins_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ins_onehot))
    else $error("insert slot select is not one-hot");

  a_ins_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_o |-> !(|(ins_onehot & keep)))
    else $error("insert targets a live entry");

  a_ins_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ins_o |=> valid_q[$past(ins_idx)])
    else $error("inserted entry not marked valid");
`endif

endmodule

// ===== rtl/lxmc_top_wrap_note.sv =====
// Request register stage of the map cache: holds one request until the
// result register can take its result. Depends on lxmc_pkg.
module lxmc_req_stage
  import lxmc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  req_t in_payload_i,
  output logic in_ready_o,
  input  logic advance_i,
  output logic valid_o,
  output req_t payload_o
);

  logic valid_q;
  req_t payload_q;

  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      payload_q <= in_payload_i;
    end
  end

  assign valid_o   = valid_q;
  assign payload_o = payload_q;

endmodule

// ===== rtl/lru_xid_map_cache.sv =====
// Top level of the LRU map from 32-bit local ids to 32-bit distributed ids.
// Depends on lxmc_pkg, lxmc_stream_if, lxmc_req_stage, lxmc_entry_store,
// lxmc_value_ram.
//
// Usage:
//   req  : request channel (opcode lookup/add, local_xid key, distrib_xid).
//   rsp  : one result per request: hit, found_distrib_xid, duplicate_error.
//   cfg  : capacity register write channel, always ready; write only while
//          no request is in flight. Capacity zero turns lookups into misses
//          and adds into no-ops; values above ENTRIES act as ENTRIES.
// Path: an accepted request goes through the request register, then the
//   compare/update logic, then the result register.
// Throughput: one request per cycle while rsp is not held off; the whole
//   lookup or add (compare of all keys, eviction, insert-slot search, rank
//   update) is combinational logic between the request and result registers.
// Reset: all entries invalid, capacity 64, both registers empty. No sweep.
// Stall: while rsp is held off, the result register holds; the request
//   register can still take one more request, after which req.ready drops.
module lru_xid_map_cache
  import lxmc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lxmc_stream_if.sink   cfg,
  lxmc_stream_if.sink   req,
  lxmc_stream_if.source rsp
);

  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  cap_t          cap_q;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;

  logic          stg_valid;
  req_t          stg_req;
  logic          advance;

  logic          st_hit;
  logic          st_dup;
  logic          st_ins;
  logic [IW-1:0] st_hit_idx;
  logic [IW-1:0] st_ins_idx;

  logic             rsp_valid_q;
  logic             hit_q;
  logic             dup_q;
  logic [XID_W-1:0] ram_rdata;

  // Capacity register; clamp to the store depth.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg.valid) begin
      cap_q <= cfg.payload;
    end
  end

  assign cap_ext = CW'(cap_q);
  assign cap_eff = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;

  // Advance the held request when the result register is free or draining.
  assign advance = stg_valid && (!rsp_valid_q || rsp.ready);

  lxmc_req_stage u_req_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req.valid),
    .in_payload_i (req.payload),
    .in_ready_o   (req.ready),
    .advance_i    (advance),
    .valid_o      (stg_valid),
    .payload_o    (stg_req)
  );

  lxmc_entry_store #(
    .ENTRIES (ENTRIES),
    .CW      (CW)
  ) u_entry_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .opcode_i  (stg_req.opcode),
    .key_i     (stg_req.local_xid),
    .cap_i     (cap_eff),
    .hit_o     (st_hit),
    .dup_o     (st_dup),
    .ins_o     (st_ins),
    .hit_idx_o (st_hit_idx),
    .ins_idx_o (st_ins_idx)
  );

  // Read the value only on a hit; its read register is part of the result.
  lxmc_value_ram #(
    .ENTRIES (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (advance && st_ins),
    .waddr_i (st_ins_idx),
    .wdata_i (stg_req.distrib_xid),
    .re_i    (advance && st_hit),
    .raddr_i (st_hit_idx),
    .rdata_o (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q <= st_hit;
      dup_q <= st_dup;
    end
  end

  assign rsp.valid                     = rsp_valid_q;
  assign rsp.payload.hit               = hit_q;
  assign rsp.payload.found_distrib_xid = hit_q ? ram_rdata : '0;
  assign rsp.payload.duplicate_error   = dup_q;

`ifndef SYNTHESIS
  a_hit_dup_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(hit_q && dup_q))
    else $error("result flags both hit and duplicate");

  a_cap_zero_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (cap_eff == '0) |=> !hit_q && !dup_q)
    else $error("disabled block produced a hit or duplicate");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> stg_valid && rsp_valid_q)
    else $error("request channel stalled with a free register");
`endif

endmodule
